### hw/rtl/spps_pkg.sv
// spps_pkg: widths, register indexes and reset values shared by the
// spectrum peak and power statistics unit and its square root unit.
// No dependencies.
`timescale 1ns / 1ps

package spps_pkg;

   localparam int SAMPLE_W       = 32;   // port width of one bin component
   localparam int RADICAND_W     = 64;   // re^2 + im^2
   localparam int ROOT_W         = 32;
   localparam int SUM_W          = 48;
   localparam int BIN_W          = 16;
   localparam int FRAME_LEN_W    = 17;
   localparam int BIN_WIDTH_W    = 32;
   localparam int FREQ_W         = 48;
   localparam int CSR_INDEX_W    = 1;
   localparam int CSR_DATA_W     = 32;

   localparam int DEFAULT_MAX_BINS     = 65536;
   localparam int DEFAULT_SAMPLE_WIDTH = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_BINS_PER_FRAME = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BIN_WIDTH_Q8   = 1'd1;

   localparam logic [FRAME_LEN_W-1:0] BINS_PER_FRAME_RESET = 17'd1024;
   localparam logic [BIN_WIDTH_W-1:0] BIN_WIDTH_Q8_RESET   = 32'd25000000;

endpackage

### hw/rtl/spps_isqrt.sv
// spps_isqrt: iterative floor square root, two radicand bits per cycle.
// Depends on spps_pkg for the radicand and root widths.
`timescale 1ns / 1ps

module spps_isqrt (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [spps_pkg::RADICAND_W-1:0] radicand,
   output logic                            done,
   output logic [spps_pkg::ROOT_W-1:0]     root
);
   import spps_pkg::*;

   localparam int STEPS   = RADICAND_W / 2;
   localparam int STEP_CW = $clog2(STEPS);

   logic [RADICAND_W-1:0] rem_ff, rem_in;
   logic [RADICAND_W-1:0] res_ff, res_in;
   logic [RADICAND_W-1:0] bit_ff, bit_in;
   logic [STEP_CW-1:0]    step_ff, step_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [RADICAND_W-1:0] trial;

   assign trial = res_ff + bit_ff;

   always_comb begin
      rem_in  = rem_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = radicand;
         res_in  = '0;
         bit_in  = {2'b01, {(RADICAND_W-2){1'b0}}};
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_ff >= trial) begin
            rem_in = rem_ff - trial;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in  = bit_ff >> 2;
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_CW'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      res_ff  <= res_in;
      bit_ff  <= bit_in;
      step_ff <= step_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign root = res_ff[ROOT_W-1:0];

endmodule

### hw/rtl/spectrum_peak_and_power_stats_unit.sv
// spectrum_peak_and_power_stats_unit: per-frame magnitude sum and peak search
// over complex spectrum bins. Depends on spps_pkg and spps_isqrt.
//
// Each accepted bin holds the input off until it is done, so a new bin is taken
// only once the last has been through its steps: re^2 and im^2 on the shared
// 32x32 multiplier, one add, and the square root unit, which resolves two
// radicand bits a cycle. The last bin of a frame then goes through the offset,
// the frequency product on the same multiplier and the result load, plus any
// wait while the previous result is still held in the output register. The
// result register is separate, so new bins are accepted while a result waits
// to be taken. Configuration may be written at any idle time; a frame length
// written mid-frame applies at once, and a bin whose index is at or past the
// new length minus one closes the frame.
`timescale 1ns / 1ps

module spectrum_peak_and_power_stats_unit #(
   parameter int MAX_BINS     = spps_pkg::DEFAULT_MAX_BINS,
   parameter int SAMPLE_WIDTH = spps_pkg::DEFAULT_SAMPLE_WIDTH
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic signed [spps_pkg::SAMPLE_W-1:0]    req_bin_real,
   input  logic signed [spps_pkg::SAMPLE_W-1:0]    req_bin_imag,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic [spps_pkg::SUM_W-1:0]              rsp_total_magnitude,
   output logic [spps_pkg::ROOT_W-1:0]             rsp_peak_magnitude,
   output logic [spps_pkg::BIN_W-1:0]              rsp_peak_bin,
   output logic signed [spps_pkg::FRAME_LEN_W-1:0] rsp_peak_offset_bin,
   output logic signed [spps_pkg::FREQ_W-1:0]      rsp_peak_freq_q8,
   input  logic                                    csr_write_enable,
   input  logic [spps_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [spps_pkg::CSR_DATA_W-1:0]         csr_data
);
   import spps_pkg::*;

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_MUL_RE = 4'd1;
   localparam logic [3:0] ST_MUL_IM = 4'd2;
   localparam logic [3:0] ST_ADD    = 4'd3;
   localparam logic [3:0] ST_SQRT   = 4'd4;
   localparam logic [3:0] ST_OFFSET = 4'd5;
   localparam logic [3:0] ST_FREQ   = 4'd6;
   localparam logic [3:0] ST_OUT    = 4'd7;

   localparam logic [FRAME_LEN_W-1:0] MAX_LEN = FRAME_LEN_W'(MAX_BINS);
   localparam logic [FRAME_LEN_W-1:0] MIN_LEN = FRAME_LEN_W'(2);
   localparam int OFF_W = FRAME_LEN_W + 1;

   function automatic logic [SAMPLE_W-1:0] abs_sample(input logic [SAMPLE_W-1:0] raw);
      logic [SAMPLE_WIDTH-1:0] v;
      v = raw[SAMPLE_WIDTH-1:0];
      if (v[SAMPLE_WIDTH-1]) begin
         v = ~v + 1'b1;
      end
      return SAMPLE_W'(v);
   endfunction

   logic [3:0]             state_ff, state_in;
   logic [FRAME_LEN_W-1:0] bins_cfg_ff;
   logic [BIN_WIDTH_W-1:0] width_cfg_ff;
   logic [SAMPLE_W-1:0]    abs_re_ff, abs_im_ff;
   logic [RADICAND_W-1:0]  prod_ff, re_sq_ff;
   logic [BIN_W-1:0]       bin_count_ff, bin_count_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic [ROOT_W-1:0]      best_mag_ff, best_mag_in;
   logic [BIN_W-1:0]       best_bin_ff, best_bin_in;
   logic [OFF_W-1:0]       offset_ff;
   logic [FRAME_LEN_W-1:0] off_abs_ff;

   logic                   rsp_valid_ff;
   logic [SUM_W-1:0]       rsp_total_ff;
   logic [ROOT_W-1:0]      rsp_peak_mag_ff;
   logic [BIN_W-1:0]       rsp_peak_bin_ff;
   logic [FRAME_LEN_W-1:0] rsp_offset_ff;
   logic [FREQ_W-1:0]      rsp_freq_ff;

   logic [SAMPLE_W-1:0]    mul_a, mul_b;
   logic [RADICAND_W-1:0]  mul_p;
   logic                   sqrt_start, sqrt_done;
   logic [ROOT_W-1:0]      sqrt_root;
   logic [FRAME_LEN_W-1:0] frame_len;
   logic [SUM_W:0]         sum_wide;
   logic [OFF_W-1:0]       offset_calc;
   logic                   req_fire, out_load;
   logic [FREQ_W-1:0]      freq_mag;

   spps_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (re_sq_ff + prod_ff),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign sqrt_start = (state_ff == ST_ADD);
   assign out_load  = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      if (bins_cfg_ff < MIN_LEN) begin
         frame_len = MIN_LEN;
      end else if (bins_cfg_ff > MAX_LEN) begin
         frame_len = MAX_LEN;
      end else begin
         frame_len = bins_cfg_ff;
      end
   end

   // shared multiplier: squares, then offset times bin width at frame end
   always_comb begin
      unique case (state_ff)
         ST_MUL_RE: begin
            mul_a = abs_re_ff;
            mul_b = abs_re_ff;
         end
         ST_MUL_IM: begin
            mul_a = abs_im_ff;
            mul_b = abs_im_ff;
         end
         default: begin
            mul_a = SAMPLE_W'(off_abs_ff);
            mul_b = width_cfg_ff;
         end
      endcase
   end
   assign mul_p = mul_a * mul_b;

   assign sum_wide = {1'b0, sum_ff} + (SUM_W+1)'(sqrt_root);

   // bins past half the frame map to negative frequency
   always_comb begin
      if ({1'b0, best_bin_ff} <= (frame_len >> 1)) begin
         offset_calc = OFF_W'(best_bin_ff);
      end else begin
         offset_calc = OFF_W'(best_bin_ff) - OFF_W'(frame_len);
      end
   end

   assign freq_mag = prod_ff[FREQ_W-1:0];

   always_comb begin
      state_in     = state_ff;
      bin_count_in = bin_count_ff;
      sum_in       = sum_ff;
      best_mag_in  = best_mag_ff;
      best_bin_in  = best_bin_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_MUL_RE;
            end
         end
         ST_MUL_RE: state_in = ST_MUL_IM;
         ST_MUL_IM: state_in = ST_ADD;
         ST_ADD:    state_in = ST_SQRT;
         ST_SQRT: begin
            if (sqrt_done) begin
               sum_in = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
               if (sqrt_root > best_mag_ff) begin
                  best_mag_in = sqrt_root;
                  best_bin_in = bin_count_ff;
               end
               if ({1'b0, bin_count_ff} >= frame_len - 1'b1) begin
                  state_in = ST_OFFSET;
               end else begin
                  bin_count_in = bin_count_ff + 1'b1;
                  state_in     = ST_IDLE;
               end
            end
         end
         ST_OFFSET: state_in = ST_FREQ;
         ST_FREQ:   state_in = ST_OUT;
         ST_OUT: begin
            if (out_load) begin
               bin_count_in = '0;
               sum_in       = '0;
               best_mag_in  = '0;
               best_bin_in  = '0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         abs_re_ff <= abs_sample(req_bin_real);
         abs_im_ff <= abs_sample(req_bin_imag);
      end
      if (state_ff == ST_MUL_RE || state_ff == ST_MUL_IM || state_ff == ST_FREQ) begin
         prod_ff <= mul_p;
      end
      if (state_ff == ST_MUL_IM) begin
         re_sq_ff <= prod_ff;
      end
      if (state_ff == ST_OFFSET) begin
         offset_ff  <= offset_calc;
         off_abs_ff <= offset_calc[OFF_W-1] ? FRAME_LEN_W'(-offset_calc)
                                            : FRAME_LEN_W'(offset_calc);
      end
      if (out_load) begin
         rsp_total_ff    <= sum_ff;
         rsp_peak_mag_ff <= best_mag_ff;
         rsp_peak_bin_ff <= best_bin_ff;
         rsp_offset_ff   <= offset_ff[FRAME_LEN_W-1:0];
         rsp_freq_ff     <= offset_ff[OFF_W-1] ? -freq_mag : freq_mag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bins_cfg_ff  <= BINS_PER_FRAME_RESET;
         width_cfg_ff <= BIN_WIDTH_Q8_RESET;
         bin_count_ff <= '0;
         sum_ff       <= '0;
         best_mag_ff  <= '0;
         best_bin_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bin_count_ff <= bin_count_in;
         sum_ff       <= sum_in;
         best_mag_ff  <= best_mag_in;
         best_bin_ff  <= best_bin_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_BINS_PER_FRAME: bins_cfg_ff  <= csr_data[FRAME_LEN_W-1:0];
               CSR_BIN_WIDTH_Q8:   width_cfg_ff <= csr_data[BIN_WIDTH_W-1:0];
               default: ;
            endcase
         end
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_total_magnitude = rsp_total_ff;
   assign rsp_peak_magnitude  = rsp_peak_mag_ff;
   assign rsp_peak_bin        = rsp_peak_bin_ff;
   assign rsp_peak_offset_bin = rsp_offset_ff;
   assign rsp_peak_freq_q8    = rsp_freq_ff;

endmodule
